// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle, off while reset is low
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the following cycle, off while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// plain condition at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, cond, msg) \
  lbl: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

// ===== design/pbe_pkg.sv =====
// types and constants of the protobuf field encoder
package pbe_pkg;

  localparam logic [2:0] KIND_VARINT = 3'd0;
  localparam logic [2:0] KIND_FIXED64 = 3'd1;
  localparam logic [2:0] KIND_LEN_HDR = 3'd2;
  localparam logic [2:0] KIND_SUBMSG = 3'd3;
  localparam logic [2:0] KIND_PAD_LEN = 3'd4;
  localparam logic [2:0] KIND_RAW = 3'd5;

  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN = 3'd2;

  localparam logic [2:0] PAD_MIN = 3'd1;
  localparam logic [2:0] PAD_MAX = 3'd5;
  localparam logic [3:0] FIXED64_BYTES = 4'd8;

  typedef enum logic [2:0] {
    BM_NONE,
    BM_VARINT,
    BM_FIXED,
    BM_PAD,
    BM_RAW
  } body_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TAG,
    PH_BODY
  } phase_e;

  typedef struct packed {
    logic        has_tag;
    logic [31:0] tag;
    body_e       body;
    logic [63:0] value;
    logic [3:0]  count;
  } job_t;

endpackage

// ===== design/pbe_if.sv =====
// valid/ready channel interfaces for encoder input items and output bytes
interface pbe_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [28:0] field_id;
  logic [63:0] value;
  logic [2:0]  pad_bytes;

  modport source (output valid, kind, field_id, value, pad_bytes, input ready);
  modport sink (input valid, kind, field_id, value, pad_bytes, output ready);
endinterface

interface pbe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface

// ===== design/pbe_front.sv =====
// front end: accepts input items and turns each known kind into a byte job
module pbe_front import pbe_pkg::*; (
  pbe_in_if.sink in_i,
  input  logic   full_i,
  output logic   push_o,
  output job_t   job_o
);

  logic known;

  assign in_i.ready = !full_i;
  assign push_o = in_i.valid && in_i.ready && known;

  always_comb begin
    known       = 1'b1;
    job_o       = '0;
    job_o.body  = BM_NONE;
    job_o.value = in_i.value;
    unique case (in_i.kind)
      KIND_VARINT: begin
        job_o.has_tag = 1'b1;
        job_o.tag     = {in_i.field_id, WT_VARINT};
        job_o.body    = BM_VARINT;
      end
      KIND_FIXED64: begin
        job_o.has_tag = 1'b1;
        job_o.tag     = {in_i.field_id, WT_FIXED64};
        job_o.body    = BM_FIXED;
        job_o.count   = FIXED64_BYTES;
      end
      KIND_LEN_HDR: begin
        job_o.has_tag = 1'b1;
        job_o.tag     = {in_i.field_id, WT_LEN};
        job_o.body    = BM_VARINT;
        job_o.value   = {32'd0, in_i.value[31:0]};
      end
      KIND_SUBMSG: begin
        job_o.has_tag = 1'b1;
        job_o.tag     = {in_i.field_id, WT_LEN};
      end
      KIND_PAD_LEN: begin
        job_o.body  = BM_PAD;
        job_o.value = {32'd0, in_i.value[31:0]};
        // pad count clamps into one to five bytes
        case (in_i.pad_bytes) inside
          3'd0:       job_o.count = {1'b0, PAD_MIN};
          3'd6, 3'd7: job_o.count = {1'b0, PAD_MAX};
          default:    job_o.count = {1'b0, in_i.pad_bytes};
        endcase
      end
      KIND_RAW: begin
        job_o.body  = BM_RAW;
        job_o.count = 4'd1;
      end
      default: known = 1'b0;
    endcase
  end

endmodule

// ===== design/pbe_queue.sv =====
// short job queue between front and back end
module pbe_queue import pbe_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t pop_job_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_job_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_job_i;
    end
  end

endmodule

// ===== design/pbe_back.sv =====
// back end: byte sequencer that walks tag then body, one byte a cycle while the output is not stalled
module pbe_back import pbe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  job_t       job_i,
  output logic       pop_o,
  pbe_out_if.source  out_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] tag_q, tag_d;
  logic [63:0] val_q, val_d;
  body_e       body_q, body_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        ovalid_q, ovalid_d;
  logic [7:0]  obyte_q, obyte_d;
  logic        olast_q, olast_d;

  logic       can_emit, emit, more, fin;
  logic [7:0] byte_w;

  assign can_emit     = !ovalid_q || out_o.ready;
  assign out_o.valid    = ovalid_q;
  assign out_o.out_byte = obyte_q;
  assign out_o.last     = olast_q;

  always_comb begin
    phase_d = phase_q;
    tag_d   = tag_q;
    val_d   = val_q;
    body_d  = body_q;
    cnt_d   = cnt_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    more    = 1'b0;
    fin     = 1'b0;
    byte_w  = '0;
    unique case (phase_q)
      PH_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          tag_d   = job_i.tag;
          val_d   = job_i.value;
          body_d  = job_i.body;
          cnt_d   = job_i.count;
          phase_d = job_i.has_tag ? PH_TAG : PH_BODY;
        end
      end
      PH_TAG: begin
        if (can_emit) begin
          emit   = 1'b1;
          more   = |tag_q[31:7];
          byte_w = {more, tag_q[6:0]};
          tag_d  = {7'd0, tag_q[31:7]};
          if (!more) begin
            fin     = (body_q == BM_NONE);
            phase_d = fin ? PH_IDLE : PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (can_emit) begin
          emit = 1'b1;
          case (body_q)
            BM_VARINT: begin
              more   = |val_q[63:7];
              byte_w = {more, val_q[6:0]};
              val_d  = {7'd0, val_q[63:7]};
              fin    = !more;
            end
            BM_FIXED: begin
              byte_w = val_q[7:0];
              val_d  = {8'd0, val_q[63:8]};
              cnt_d  = cnt_q - 1'b1;
              fin    = (cnt_q == 4'd1);
            end
            BM_PAD: begin
              // continuation bit on all but the final byte, spare bits dropped
              byte_w = {cnt_q != 4'd1, val_q[6:0]};
              val_d  = {7'd0, val_q[63:7]};
              cnt_d  = cnt_q - 1'b1;
              fin    = (cnt_q == 4'd1);
            end
            BM_RAW: begin
              byte_w = val_q[7:0];
              fin    = 1'b1;
            end
            default: begin
              emit = 1'b0;
              fin  = 1'b1;
            end
          endcase
          if (fin) begin
            phase_d = PH_IDLE;
          end
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    if (emit) begin
      ovalid_d = 1'b1;
      obyte_d  = byte_w;
      olast_d  = fin;
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q   <= tag_d;
    val_q   <= val_d;
    body_q  <= body_d;
    cnt_q   <= cnt_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

endmodule

// ===== design/protobuf_field_encoder.sv =====
// Protobuf wire-format field encoder. Each accepted item becomes a run of output
// words, one byte each, with last set on the final byte of the item: a tag varint
// and a varint, fixed64 or length body, a lone tag varint, a padded length varint,
// or one raw byte. Unused kinds are accepted and produce nothing. The front end
// classifies an item in the cycle it is accepted and queues a job; the back-end
// byte sequencer then loads the job and emits its bytes one by one, up to 15 bytes
// for a varint field with a five-byte tag and a ten-byte value. Input is taken
// while the job queue has room, independently of output stalls.
module protobuf_field_encoder import pbe_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pbe_in_if.sink    in_i,
  pbe_out_if.source out_o
);

  logic push, full, pop, empty;
  job_t push_job, pop_job;

  pbe_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  pbe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_job_o  (pop_job)
  );

  pbe_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .job_i   (pop_job),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== design/pbe_checker.sv =====
// port-level assertions for the protobuf field encoder, bound to the top level
`include "assert_macros.svh"

module pbe_checker import pbe_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [2:0] in_kind_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i
);

  // items of known kind taken in whose final byte has not yet gone out
  logic [7:0] pending_q, pending_d;
  logic       in_take, out_done;

  assign in_take  = in_valid_i && in_ready_i && (in_kind_i <= KIND_RAW);
  assign out_done = out_valid_i && out_ready_i && out_last_i;

  always_comb begin
    pending_d = pending_q;
    if (in_take && !out_done) begin
      pending_d = pending_q + 1'b1;
    end else if (out_done && !in_take) begin
      pending_d = pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // valid may still be unknown at the first edges, only a high valid counts
  `ASSERT_ALWAYS(a_reset_quiet, clk_i, rst_ni || out_valid_i !== 1'b1, "output word during reset")
  `ASSERT_IMPL(a_no_stray_word, clk_i, rst_ni, out_valid_i, pending_q != '0, "word without item")
  `ASSERT_NEXT(a_valid_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "valid dropped")
  `ASSERT_NEXT(a_word_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_byte_i) && $stable(out_last_i), "stalled word changed")

endmodule

bind protobuf_field_encoder pbe_checker u_pbe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_kind_i   (in_i.kind),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_last_i  (out_o.last)
);

// ===== bench/tb_top.sv =====
// self-checking bench for the protobuf field encoder: table-driven and random items
module tb_top;
  import pbe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD       = 8;
  localparam int RESET_CYCLES     = 3;
  localparam int RANDOM_ITEMS     = 76;
  localparam int LONG_HOLD_AFTER  = 50;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 24;
  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int NUM_DIRECTED     = 24;

  // kinds the encoder accepts but turns into nothing
  localparam logic [2:0] KIND_UNUSED_LO = 3'd6;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [2:0]   kind;
    logic [28:0]  field_id;
    logic [63:0]  value;
    logic [2:0]   pad_bytes;
    logic         typed;
    logic [3:0]   typed_n;
    logic [119:0] typed_bytes;
  } stim_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pbe_in_if  in_bus ();
  pbe_out_if out_bus ();

  protobuf_field_encoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  out_word_t  expected_words [$];
  logic [7:0] enc_bytes [$];
  int         error_count    = 0;
  int         items_accepted = 0;
  bit         burst_mode     = 1'b0;

  // typed rows list their bytes with the first byte in the low bits
  stim_t directed_rows [NUM_DIRECTED] = '{
    '{KIND_RAW,      29'd0,         64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 1'b1, 4'd1, 120'hFF},
    '{KIND_RAW,      29'h1FFF_FFFF, 64'h0,                   3'd7, 1'b1, 4'd1, 120'h00},
    '{KIND_SUBMSG,   29'd0,         64'h0,                   3'd0, 1'b1, 4'd1, 120'h02},
    '{KIND_SUBMSG,   29'd1,         64'h0,                   3'd0, 1'b1, 4'd1, 120'h0A},
    '{KIND_VARINT,   29'd0,         64'h0,                   3'd0, 1'b1, 4'd2, 120'h0000},
    '{KIND_VARINT,   29'd0,         64'h1,                   3'd0, 1'b1, 4'd2, 120'h0100},
    '{KIND_FIXED64,  29'd0,         64'h0,                   3'd0, 1'b1, 4'd9, 120'h01},
    '{KIND_LEN_HDR,  29'd0,         64'h0,                   3'd0, 1'b1, 4'd2, 120'h02},
    '{KIND_UNUSED_LO, 29'd5,        64'h1234,                3'd2, 1'b1, 4'd0, 120'h0},
    '{KIND_UNUSED_HI, 29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 1'b1, 4'd0, 120'h0},
    '{KIND_PAD_LEN,  29'd0,         64'h0,                   3'd1, 1'b1, 4'd1, 120'h00},
    '{KIND_PAD_LEN,  29'd0,         64'h7F,                  3'd0, 1'b1, 4'd1, 120'h7F},
    '{KIND_PAD_LEN,  29'd0,         64'h0,                   3'd7, 1'b1, 4'd5, 120'h00_8080_8080},
    '{KIND_PAD_LEN,  29'd3,         64'hFFFF_FFFF_FFFF_FFFF, 3'd6, 1'b0, 4'd0, 120'h0},
    '{KIND_PAD_LEN,  29'd0,         64'h1234_5678,           3'd5, 1'b0, 4'd0, 120'h0},
    '{KIND_PAD_LEN,  29'd0,         64'hFFFF,                3'd2, 1'b0, 4'd0, 120'h0},
    '{KIND_VARINT,   29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 1'b0, 4'd0, 120'h0},
    '{KIND_VARINT,   29'd15,        64'h7F,                  3'd0, 1'b0, 4'd0, 120'h0},
    '{KIND_VARINT,   29'd16,        64'h80,                  3'd0, 1'b0, 4'd0, 120'h0},
    '{KIND_FIXED64,  29'h1FFF_FFFF, 64'h0123_4567_89AB_CDEF, 3'd0, 1'b0, 4'd0, 120'h0},
    '{KIND_LEN_HDR,  29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 1'b0, 4'd0, 120'h0},
    '{KIND_SUBMSG,   29'h1FFF_FFFF, 64'h0,                   3'd0, 1'b0, 4'd0, 120'h0},
    '{KIND_VARINT,   29'd1,         64'h8000_0000_0000_0000, 3'd0, 1'b0, 4'd0, 120'h0},
    '{KIND_RAW,      29'd12345,     64'hA5,                  3'd3, 1'b0, 4'd0, 120'h0}
  };

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // leb128: seven bits per byte, low group first, continuation in bit 7
  function automatic void push_varint(input logic [63:0] v);
    while (v >= 64'h80) begin
      enc_bytes.push_back({1'b1, v[6:0]});
      v = v >> 7;
    end
    enc_bytes.push_back({1'b0, v[6:0]});
  endfunction

  function automatic void encode_field(input stim_t s);
    logic [31:0] v32;
    logic [2:0]  pad;
    enc_bytes.delete();
    case (s.kind)
      KIND_VARINT: begin
        push_varint({32'd0, s.field_id, WT_VARINT});
        push_varint(s.value);
      end
      KIND_FIXED64: begin
        push_varint({32'd0, s.field_id, WT_FIXED64});
        for (int i = 0; i < FIXED64_BYTES; i++) enc_bytes.push_back(s.value[8*i +: 8]);
      end
      KIND_LEN_HDR: begin
        push_varint({32'd0, s.field_id, WT_LEN});
        push_varint({32'd0, s.value[31:0]});
      end
      KIND_SUBMSG: push_varint({32'd0, s.field_id, WT_LEN});
      KIND_PAD_LEN: begin
        v32 = s.value[31:0];
        pad = s.pad_bytes;
        if (pad < PAD_MIN) pad = PAD_MIN;
        if (pad > PAD_MAX) pad = PAD_MAX;
        // redundant varint, top bits dropped if they do not fit
        for (int i = 0; i + 1 < pad; i++) begin
          enc_bytes.push_back({1'b1, v32[6:0]});
          v32 = v32 >> 7;
        end
        enc_bytes.push_back({1'b0, v32[6:0]});
      end
      KIND_RAW: enc_bytes.push_back(s.value[7:0]);
      default: ;
    endcase
  endfunction

  task automatic offer_field(input stim_t s);
    int gap;
    gap = burst_mode ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_bus.valid     <= 1'b0;
      in_bus.kind      <= 3'($urandom);
      in_bus.field_id  <= 29'($urandom);
      in_bus.value     <= {$urandom, $urandom};
      in_bus.pad_bytes <= 3'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.kind      <= s.kind;
    in_bus.field_id  <= s.field_id;
    in_bus.value     <= s.value;
    in_bus.pad_bytes <= s.pad_bytes;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    items_accepted++;
    if (s.typed) begin
      enc_bytes.delete();
      for (int i = 0; i < s.typed_n; i++) enc_bytes.push_back(s.typed_bytes[8*i +: 8]);
    end else begin
      encode_field(s);
    end
    foreach (enc_bytes[i])
      expected_words.push_back({enc_bytes[i], i == enc_bytes.size() - 1});
  endtask

  // output side: compare every accepted word with the oldest expectation
  always @(posedge clk_i) begin
    out_word_t exp_word;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word %02h last %0b", $time, out_bus.out_byte, out_bus.last);
        error_count++;
      end else begin
        exp_word = expected_words.pop_front();
        if (out_bus.out_byte !== exp_word.data) begin
          $display("%0t: out_byte expected %02h got %02h", $time, exp_word.data,
                   out_bus.out_byte);
          error_count++;
        end
        if (out_bus.last !== exp_word.last) begin
          $display("%0t: last expected %0b got %0b", $time, exp_word.last, out_bus.last);
          error_count++;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off so the job queue fills up
  initial begin : sink_side
    int stall_left;
    int busy_left;
    bit held;
    stall_left = 0;
    busy_left  = 0;
    held       = 1'b0;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && items_accepted >= LONG_HOLD_AFTER) begin
        held       = 1'b1;
        stall_left = LONG_HOLD_CYCLES;
        busy_left  = 0;
      end
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else if (busy_left > 0) begin
        out_bus.ready <= 1'b1;
        busy_left--;
      end else begin
        stall_left = pick_gap();
        busy_left  = $urandom_range(1, 40);
        out_bus.ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
        else busy_left--;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : source_side
    stim_t s;
    int    real_items;
    int    r;
    in_bus.valid     = 1'b0;
    in_bus.kind      = KIND_VARINT;
    in_bus.field_id  = '0;
    in_bus.value     = '0;
    in_bus.pad_bytes = '0;
    rst_ni = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) offer_field(directed_rows[i]);

    real_items = 0;
    while (real_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      s = '0;
      if (r < 4) begin
        s.kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      end else begin
        s.kind = 3'($urandom_range(KIND_VARINT, KIND_RAW));
        real_items++;
      end
      // spread tag and value lengths over every varint size
      s.field_id  = 29'($urandom >> $urandom_range(3, 31));
      s.value     = {$urandom, $urandom} >> $urandom_range(0, 63);
      s.pad_bytes = 3'($urandom_range(0, 7));
      burst_mode  = (real_items >= 50 && real_items < 65);
      offer_field(s);
    end
    @(negedge clk_i);
    in_bus.valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/pbe_pkg.sv
design/pbe_if.sv
design/pbe_front.sv
design/pbe_queue.sv
design/pbe_back.sv
design/protobuf_field_encoder.sv
design/pbe_checker.sv
bench/tb_top.sv
